>>> design/lsehd_pkg.sv
// ----------------------------------------------------------------------------
// lsehd_pkg: shared types and codes of the level-set Hermite edge data unit
// Holds the queued command word, the result word, the register file view
// and the command and register codes.
// ----------------------------------------------------------------------------
package lsehd_pkg;

  // Coordinates travel at 8 bits, room for grids of up to 256 cells a side.
  localparam int COORD_W  = 8;
  localparam int SAMPLE_W = 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [2:0] REG_SPACING_X = 3'd0;
  localparam logic [2:0] REG_SPACING_Y = 3'd1;
  localparam logic [2:0] REG_SPACING_Z = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd5;

  localparam logic [30:0] SPACING_RESET = 31'd2048;

  typedef struct packed {
    logic                cmd;
    logic [COORD_W-1:0]  z;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  x;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [2:0][30:0] spacing;
    logic [2:0][31:0] origin;
  } cfg_t;

  typedef struct packed {
    logic             last;
    logic [2:0][15:0] normal;
    logic [2:0][31:0] point;
    logic [1:0]       axis;
  } res_t;

endpackage

>>> design/level_set_edge_hermite_data_unit.sv
// ----------------------------------------------------------------------------
// level_set_edge_hermite_data_unit: Hermite edge data for dual contouring
// Stores a cubic grid of signed samples and reports, per evaluated cell,
// the crossing point and unit normal of each lower face whose sign flips.
// ----------------------------------------------------------------------------
//
//  channel | dir | word contents (low bit first)
//  --------+-----+--------------------------------------------------------
//  in_     | in  | tdata: cell_x, cell_y, cell_z, sample; tuser: command
//  out_    | out | tdata: point_x/y/z, normal_x/y/z; tuser: face_axis;
//          |     | tlast: final crossing of the cell
//  cfg_    | in  | index 0..2 spacing x/y/z, 3..5 origin x/y/z
//
// A write is done while the engine is idle. An evaluation gathers the cell
// and its lower neighbors, then works through each crossing face with the
// shared one-bit-per-cycle divider (seven 64-step divisions: point, three
// gradient components, three normal components) and the 32-step square
// root. A four-word queue lets the input run ahead of the engine; the
// output register holds a result while the engine works on. Reset is
// synchronous and active low; the grid has no clearing pass and its entries
// are undefined until written.
// ----------------------------------------------------------------------------
module level_set_edge_hermite_data_unit #(
  parameter int GRID_SIZE    = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // cell_x[4:0], cell_y[9:5], cell_z[14:10], sample[30:15]
  input  logic         in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // point_x, point_y, point_z, normal_x, normal_y, normal_z
  output logic [1:0]   out_tuser,  // face_axis
  output logic         out_tlast
);

  localparam int ITEM_W = $bits(lsehd_pkg::item_t);

  lsehd_pkg::cfg_t  cfg_r;
  lsehd_pkg::item_t push_item, q_item;
  lsehd_pkg::res_t  res, out_res_r;
  logic [ITEM_W-1:0] push_bits, head_bits;
  logic             push, q_full, q_valid, q_ready;
  logic             res_valid, res_ready;
  logic             out_valid_r;

  // register file: spacing keeps its low 31 bits, unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        cfg_r.spacing[k] <= lsehd_pkg::SPACING_RESET;
        cfg_r.origin[k]  <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        lsehd_pkg::REG_SPACING_X: cfg_r.spacing[0] <= cfg_wdata[30:0];
        lsehd_pkg::REG_SPACING_Y: cfg_r.spacing[1] <= cfg_wdata[30:0];
        lsehd_pkg::REG_SPACING_Z: cfg_r.spacing[2] <= cfg_wdata[30:0];
        lsehd_pkg::REG_ORIGIN_X:  cfg_r.origin[0]  <= cfg_wdata;
        lsehd_pkg::REG_ORIGIN_Y:  cfg_r.origin[1]  <= cfg_wdata;
        lsehd_pkg::REG_ORIGIN_Z:  cfg_r.origin[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lsehd_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  assign push_bits = push_item;
  assign q_item    = head_bits;

  lsehd_fifo #(.WIDTH(ITEM_W), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_bits),
    .full      (q_full),
    .pop       (q_ready),
    .not_empty (q_valid),
    .head      (head_bits)
  );

  lsehd_engine #(.GRID_SIZE(GRID_SIZE), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: load when empty or when the current word leaves
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.normal, out_res_r.point};
  assign out_tuser  = out_res_r.axis;
  assign out_tlast  = out_res_r.last;

endmodule

>>> design/lsehd_ram.sv
// ----------------------------------------------------------------------------
// lsehd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsehd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/lsehd_div.sv
// ----------------------------------------------------------------------------
// lsehd_div: shared unsigned restoring divider
// 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsehd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] quot_r, quot_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_r, quot_r[63]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd64;
      quot_nxt = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when the divisor fits
      rem_nxt  = fits ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      quot_nxt = {quot_r[62:0], fits};
      cnt_nxt  = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

>>> design/lsehd_fifo.sv
// ----------------------------------------------------------------------------
// lsehd_fifo: short command queue
// Decouples the accepting front from the evaluating engine.
// ----------------------------------------------------------------------------
module lsehd_fifo #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             do_pop;

  assign full      = count_r == (PW+1)'(DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slots[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/lsehd_front.sv
// ----------------------------------------------------------------------------
// lsehd_front: input acceptance and classification
// Unpacks the input word, drops cells outside the grid, queues the rest.
// ----------------------------------------------------------------------------
module lsehd_front #(
  parameter int GRID_SIZE = 32
) (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,
  input  logic                in_tuser,
  input  logic                q_full,
  output logic                push,
  output lsehd_pkg::item_t    push_item
);

  logic [4:0] cx, cy, cz;
  logic       in_grid;

  assign cx = in_tdata[4:0];
  assign cy = in_tdata[9:5];
  assign cz = in_tdata[14:10];

  assign in_grid = ({27'd0, cx} < 32'(GRID_SIZE)) && ({27'd0, cy} < 32'(GRID_SIZE))
                && ({27'd0, cz} < 32'(GRID_SIZE));

  assign in_tready = !q_full;
  // drop words for cells outside the grid: they give no result and write nothing
  assign push = in_tvalid && !q_full && in_grid;

  always_comb begin
    push_item        = '0;
    push_item.cmd    = in_tuser;
    push_item.x      = lsehd_pkg::COORD_W'(cx);
    push_item.y      = lsehd_pkg::COORD_W'(cy);
    push_item.z      = lsehd_pkg::COORD_W'(cz);
    push_item.sample = in_tdata[30:15];
  end

endmodule

>>> design/lsehd_engine.sv
// ----------------------------------------------------------------------------
// lsehd_engine: grid store and face evaluation sequencer
// Executes writes into the sample RAM and walks evaluations: gathers the
// cell and its lower neighbors, then per crossing face the tangential
// samples, the point, the gradient, its norm and the unit normal.
// ----------------------------------------------------------------------------
module lsehd_engine #(
  parameter int GRID_SIZE    = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lsehd_pkg::cfg_t  cfg,
  input  logic             q_valid,
  input  lsehd_pkg::item_t q_item,
  output logic             q_ready,
  output logic             res_valid,
  input  logic             res_ready,
  output lsehd_pkg::res_t  res
);

  localparam int SWE   = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
  localparam int CW    = $clog2(GRID_SIZE);
  localparam int DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = SWE + 4;
  localparam int DNW   = SWE + 1;
  localparam int PRW   = CW + 32;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_GRD   = 5'd1;
  localparam logic [4:0] S_GCAP  = 5'd2;
  localparam logic [4:0] S_GEVAL = 5'd3;
  localparam logic [4:0] S_FACE  = 5'd4;
  localparam logic [4:0] S_TRD   = 5'd5;
  localparam logic [4:0] S_TCAP  = 5'd6;
  localparam logic [4:0] S_PMUL  = 5'd7;
  localparam logic [4:0] S_PNF   = 5'd8;
  localparam logic [4:0] S_PX1   = 5'd9;
  localparam logic [4:0] S_PX2   = 5'd10;
  localparam logic [4:0] S_DGO   = 5'd11;
  localparam logic [4:0] S_DWAIT = 5'd12;
  localparam logic [4:0] S_SHIFT = 5'd13;
  localparam logic [4:0] S_SQ    = 5'd14;
  localparam logic [4:0] S_ACC   = 5'd15;
  localparam logic [4:0] S_SQI   = 5'd16;
  localparam logic [4:0] S_SQRT  = 5'd17;
  localparam logic [4:0] S_EMIT  = 5'd18;

  localparam logic [1:0] DK_POINT = 2'd0;
  localparam logic [1:0] DK_GRAD  = 2'd1;
  localparam logic [1:0] DK_NORM  = 2'd2;

  function automatic logic [AW-1:0] addr_of(input logic [2:0][CW-1:0] c);
    addr_of = AW'(c[0]) * AW'(GRID_SIZE * GRID_SIZE) + AW'(c[1]) * AW'(GRID_SIZE)
            + AW'(c[2]);
  endfunction

  function automatic logic [1:0] lowest(input logic [2:0] m);
    if (m[0]) begin
      lowest = 2'd0;
    end else if (m[1]) begin
      lowest = 2'd1;
    end else begin
      lowest = 2'd2;
    end
  endfunction

  function automatic logic [31:0] sat32(input logic [65:0] v);
    if (v[65:31] == '0 || v[65:31] == '1) begin
      sat32 = v[31:0];
    end else begin
      sat32 = v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  endfunction

  // registers
  logic [4:0]           state_r, state_nxt;
  logic [2:0][CW-1:0]   p_r, p_nxt;
  logic [SWE-1:0]       c_r, c_nxt;
  logic [2:0][SWE-1:0]  nb_r, nb_nxt;
  logic [2:0]           mask_r, mask_nxt;
  logic [1:0]           axis_r, axis_nxt;
  logic [2:0]           slot_r, slot_nxt;
  logic [1:0]           b_r, b_nxt;
  logic [2:0][DW-1:0]   d_r, d_nxt;
  logic [PRW-1:0]       prod_r, prod_nxt;
  logic [63:0]          xacc_r, xacc_nxt;
  logic [2:0][31:0]     pt_r, pt_nxt;
  logic [2:0][63:0]     mag_r, mag_nxt;
  logic [63:0]          sq_r, sq_nxt;
  logic [63:0]          sum_r, sum_nxt;
  logic [63:0]          sv_r, sv_nxt;
  logic [63:0]          sres_r, sres_nxt;
  logic [63:0]          sbit_r, sbit_nxt;
  logic [31:0]          norm_r, norm_nxt;
  logic [2:0][15:0]     nrm_r, nrm_nxt;
  logic [1:0]           dkind_r, dkind_nxt;

  // memory and divider
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [SWE-1:0]       ram_rdata;
  logic                 div_start, div_busy, div_done;
  logic [63:0]          div_num, div_quot;
  logic [31:0]          div_den;

  // datapath helpers
  logic [2:0][CW-1:0]   q_coord, g_coord, t_coord;
  logic [1:0]           gk, b0, b1, tb;
  logic [1:0]           tkind;
  logic                 tclamp;
  logic [SWE-1:0]       n_sel;
  logic signed [SWE:0]  diff_s;
  logic [DNW-1:0]       den_u, num_u;
  logic signed [DW-1:0] da_w;
  logic signed [SWE-1:0] tval_s;
  logic [DW-1:0]        tv;
  logic [2:0]           mask_w, axbit, mask_left;
  logic [30:0]          hb;
  logic [65:0]          ob_ext;
  logic [CW:0]          fac;
  logic [PRW:0]         half_w;
  logic [PRW+DNW-1:0]   pxd_w;
  logic [31+DNW-1:0]    hn_w;
  logic [DW-1:0]        absd;
  logic                 big_w;
  logic [63:0]          sq_w;
  logic [63:0]          strial;
  logic [15:0]          r16;

  lsehd_ram #(.WIDTH(SWE), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_item.sample[SWE-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lsehd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign q_coord[0] = q_item.x[CW-1:0];
  assign q_coord[1] = q_item.y[CW-1:0];
  assign q_coord[2] = q_item.z[CW-1:0];
  assign ram_waddr  = addr_of(q_coord);

  // neighbor gather: slot 0 is the cell, slots 1..3 its lower neighbors
  assign gk = slot_r[1:0] - 2'd1;
  always_comb begin
    g_coord = p_r;
    if (slot_r != '0 && p_r[gk] != '0) begin
      g_coord[gk] = p_r[gk] - CW'(1);
    end
  end

  // tangential reads: per axis, P+e, Q+e, P-e, Q-e
  assign b0    = (axis_r == 2'd0) ? 2'd1 : 2'd0;
  assign b1    = (axis_r == 2'd2) ? 2'd1 : 2'd2;
  assign tb    = slot_r[2] ? b1 : b0;
  assign tkind = slot_r[1:0];
  assign tclamp = tkind[1] ? (p_r[tb] == '0) : (p_r[tb] == CW'(GRID_SIZE - 1));
  always_comb begin
    t_coord = p_r;
    if (tkind[0]) begin
      t_coord[axis_r] = p_r[axis_r] - CW'(1);
    end
    if (!tclamp) begin
      t_coord[tb] = tkind[1] ? p_r[tb] - CW'(1) : p_r[tb] + CW'(1);
    end
  end

  assign ram_raddr = (state_r == S_TRD || state_r == S_TCAP) ? addr_of(t_coord)
                                                             : addr_of(g_coord);

  assign n_sel  = nb_r[axis_r];
  assign diff_s = $signed({n_sel[SWE-1], n_sel}) - $signed({c_r[SWE-1], c_r});
  assign den_u  = diff_s[SWE] ? DNW'(-diff_s) : DNW'(diff_s);
  assign num_u  = diff_s[SWE] ? DNW'(-$signed({n_sel[SWE-1], n_sel}))
                              : DNW'({n_sel[SWE-1], n_sel});
  assign da_w   = -(DW'(diff_s)) <<< 2;
  assign tval_s = tclamp ? (tkind[0] ? n_sel : c_r) : ram_rdata;
  assign tv     = DW'(tval_s);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mask_w[k] = (p_r[k] != '0) && (nb_r[k][SWE-1] != c_r[SWE-1]);
    end
  end
  assign axbit     = 3'd1 << axis_r;
  assign mask_left = mask_r & ~axbit;

  assign hb     = (cfg.spacing[b_r] == '0) ? 31'd1 : cfg.spacing[b_r];
  assign ob_ext = 66'($signed(cfg.origin[b_r]));
  assign fac    = (b_r == axis_r) ? ({p_r[b_r], 1'b1} - (CW+1)'(2)) : {p_r[b_r], 1'b1};
  assign half_w = ({1'b0, prod_r} + (PRW+1)'(1)) >> 1;
  assign pxd_w  = (PRW+DNW)'(prod_r) * (PRW+DNW)'(den_u);
  assign hn_w   = (31+DNW)'(hb) * (31+DNW)'(num_u);
  assign absd   = d_r[b_r][DW-1] ? -d_r[b_r] : d_r[b_r];
  assign big_w  = (mag_r[0][63:31] != '0) || (mag_r[1][63:31] != '0)
               || (mag_r[2][63:31] != '0);
  assign sq_w   = 64'(mag_r[b_r][30:0]) * 64'(mag_r[b_r][30:0]);
  assign strial = sres_r + sbit_r;
  assign r16    = d_r[b_r][DW-1] ? 16'(-div_quot[15:0]) : div_quot[15:0];

  always_comb begin
    case (dkind_r)
      DK_POINT: begin
        div_num = xacc_r;
        div_den = 32'({den_u, 1'b0});
      end
      DK_GRAD: begin
        div_num = 64'(absd) << 40;
        div_den = 32'(hb);
      end
      default: begin
        div_num = 64'({mag_r[b_r][30:0], 14'd0}) + 64'(norm_r >> 1);
        div_den = norm_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    c_nxt     = c_r;
    nb_nxt    = nb_r;
    mask_nxt  = mask_r;
    axis_nxt  = axis_r;
    slot_nxt  = slot_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    prod_nxt  = prod_r;
    xacc_nxt  = xacc_r;
    pt_nxt    = pt_r;
    mag_nxt   = mag_r;
    sq_nxt    = sq_r;
    sum_nxt   = sum_r;
    sv_nxt    = sv_r;
    sres_nxt  = sres_r;
    sbit_nxt  = sbit_r;
    norm_nxt  = norm_r;
    nrm_nxt   = nrm_r;
    dkind_nxt = dkind_r;
    ram_we    = 1'b0;
    div_start = 1'b0;
    res_valid = 1'b0;
    q_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_item.cmd == lsehd_pkg::CMD_WRITE) begin
            ram_we = 1'b1;
          end else begin
            p_nxt     = q_coord;
            slot_nxt  = '0;
            state_nxt = S_GRD;
          end
        end
      end
      S_GRD: begin
        state_nxt = S_GCAP;
      end
      S_GCAP: begin
        if (slot_r == '0) begin
          c_nxt = ram_rdata;
        end else begin
          nb_nxt[gk] = ram_rdata;
        end
        if (slot_r == 3'd3) begin
          state_nxt = S_GEVAL;
        end else begin
          slot_nxt  = slot_r + 3'd1;
          state_nxt = S_GRD;
        end
      end
      S_GEVAL: begin
        if (mask_w == '0) begin
          state_nxt = S_IDLE;
        end else begin
          mask_nxt  = mask_w;
          axis_nxt  = lowest(mask_w);
          state_nxt = S_FACE;
        end
      end
      S_FACE: begin
        d_nxt         = '0;
        d_nxt[axis_r] = da_w;
        slot_nxt      = '0;
        state_nxt     = S_TRD;
      end
      S_TRD: begin
        state_nxt = S_TCAP;
      end
      S_TCAP: begin
        // upper samples add, lower samples subtract
        d_nxt[tb] = tkind[1] ? d_r[tb] - tv : d_r[tb] + tv;
        if (slot_r == 3'd7) begin
          b_nxt     = '0;
          state_nxt = S_PMUL;
        end else begin
          slot_nxt  = slot_r + 3'd1;
          state_nxt = S_TRD;
        end
      end
      S_PMUL: begin
        prod_nxt  = PRW'(fac) * PRW'(hb);
        state_nxt = (b_r == axis_r) ? S_PX1 : S_PNF;
      end
      S_PNF: begin
        pt_nxt[b_r] = sat32(ob_ext + 66'(half_w));
        if (b_r == 2'd2) begin
          b_nxt     = '0;
          dkind_nxt = DK_GRAD;
          state_nxt = S_DGO;
        end else begin
          b_nxt     = b_r + 2'd1;
          state_nxt = S_PMUL;
        end
      end
      S_PX1: begin
        xacc_nxt  = 64'(pxd_w);
        state_nxt = S_PX2;
      end
      S_PX2: begin
        xacc_nxt  = xacc_r + 64'({hn_w, 1'b0}) + 64'(den_u);
        dkind_nxt = DK_POINT;
        state_nxt = S_DGO;
      end
      S_DGO: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          case (dkind_r)
            DK_POINT: begin
              pt_nxt[b_r] = sat32(ob_ext + {2'b00, div_quot});
              if (b_r == 2'd2) begin
                b_nxt     = '0;
                dkind_nxt = DK_GRAD;
                state_nxt = S_DGO;
              end else begin
                b_nxt     = b_r + 2'd1;
                state_nxt = S_PMUL;
              end
            end
            DK_GRAD: begin
              mag_nxt[b_r] = div_quot;
              if (b_r == 2'd2) begin
                state_nxt = S_SHIFT;
              end else begin
                b_nxt     = b_r + 2'd1;
                state_nxt = S_DGO;
              end
            end
            default: begin
              nrm_nxt[b_r] = r16;
              if (b_r == 2'd2) begin
                state_nxt = S_EMIT;
              end else begin
                b_nxt     = b_r + 2'd1;
                state_nxt = S_DGO;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        // scale all three magnitudes until the largest fits 31 bits
        if (big_w) begin
          for (int k = 0; k < 3; k++) begin
            mag_nxt[k] = mag_r[k] >> 1;
          end
        end else begin
          b_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        sq_nxt    = sq_w;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        sum_nxt = sum_r + sq_r;
        if (b_r == 2'd2) begin
          state_nxt = S_SQI;
        end else begin
          b_nxt     = b_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_SQI: begin
        sv_nxt    = sum_r;
        sres_nxt  = '0;
        sbit_nxt  = 64'd1 << 62;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sbit_r == '0) begin
          norm_nxt  = (sres_r == '0) ? 32'd1 : sres_r[31:0];
          b_nxt     = '0;
          dkind_nxt = DK_NORM;
          state_nxt = S_DGO;
        end else begin
          if (sv_r >= strial) begin
            sv_nxt   = sv_r - strial;
            sres_nxt = (sres_r >> 1) + sbit_r;
          end else begin
            sres_nxt = sres_r >> 1;
          end
          sbit_nxt = sbit_r >> 2;
        end
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          mask_nxt = mask_left;
          if (mask_left == '0) begin
            state_nxt = S_IDLE;
          end else begin
            axis_nxt  = lowest(mask_left);
            state_nxt = S_FACE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    p_r     <= p_nxt;
    c_r     <= c_nxt;
    nb_r    <= nb_nxt;
    mask_r  <= mask_nxt;
    axis_r  <= axis_nxt;
    slot_r  <= slot_nxt;
    b_r     <= b_nxt;
    d_r     <= d_nxt;
    prod_r  <= prod_nxt;
    xacc_r  <= xacc_nxt;
    pt_r    <= pt_nxt;
    mag_r   <= mag_nxt;
    sq_r    <= sq_nxt;
    sum_r   <= sum_nxt;
    sv_r    <= sv_nxt;
    sres_r  <= sres_nxt;
    sbit_r  <= sbit_nxt;
    norm_r  <= norm_nxt;
    nrm_r   <= nrm_nxt;
    dkind_r <= dkind_nxt;
  end

  always_comb begin
    res        = '0;
    res.axis   = axis_r;
    res.point  = pt_r;
    res.normal = nrm_r;
    res.last   = (mask_left == '0);
  end

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_emit_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> mask_r[axis_r]) else $error("emit for face not in mask");

  a_norm_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DGO && dkind_r == DK_NORM) |-> norm_r != '0)
    else $error("zero norm at normalize");

  a_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |-> mag_r[b_r][63:31] == '0)
    else $error("gradient magnitude not scaled before square");

endmodule
